// File: rtl/tap_pkg.sv
// Shared types, constants and helper functions of the tensor axis permute address generator.
package tap_pkg;

    localparam int NUM_AXES      = 4;
    localparam int MAX_AXIS_SIZE = 4096;
    localparam int COORD_BITS    = $clog2(MAX_AXIS_SIZE);
    localparam int SIZE_BITS     = 13;
    localparam int ORDER_BITS    = 2;
    localparam int INDEX_BITS    = 24;
    localparam int DATA_BITS     = 32;
    localparam int ERR_BITS      = 2;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = SIZE_BITS;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_0  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_1  = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_2  = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_3  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_0 = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_1 = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_2 = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_3 = 4'd7;

    // Error codes on the result.
    localparam logic [ERR_BITS-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_ORDER = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_COUNT = 2'd2;

    // Configuration as seen by the datapath: sizes are already clamped.
    typedef struct packed {
        logic [NUM_AXES-1:0][SIZE_BITS-1:0]  size;
        logic [NUM_AXES-1:0][ORDER_BITS-1:0] order;
    } t_cfg;

    // One item on its way from the front to the back.
    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_BITS-1:0] coord;
        logic [DATA_BITS-1:0]                data;
        logic                                last;
    } t_item;

    // A size of zero counts as one, and sizes saturate at the axis maximum.
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_BITS'(1);
        end else if (s > SIZE_BITS'(MAX_AXIS_SIZE)) begin
            r = SIZE_BITS'(MAX_AXIS_SIZE);
        end
        return r;
    endfunction

    // True when every source axis appears exactly once in the order.
    function automatic logic perm_ok(input logic [NUM_AXES-1:0][ORDER_BITS-1:0] ord);
        logic [NUM_AXES-1:0] seen;
        seen = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            seen[ord[k]] = 1'b1;
        end
        return &seen;
    endfunction

endpackage

// File: rtl/tap_front.sv
// Front end: accepts items and tags each with its source coordinate and last flag.
module tap_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [tap_pkg::DATA_BITS-1:0]  i_data,
    input  tap_pkg::t_cfg                  i_cfg,
    input  logic                           i_restart,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output tap_pkg::t_item                 o_q_item
);
    import tap_pkg::*;

    logic [NUM_AXES-1:0][COORD_BITS-1:0] r_coord;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] n_coord;
    logic [NUM_AXES-1:0]                 w_wrap;
    logic [NUM_AXES-1:0]                 w_inc;

    // Odometer step: axis 3 is the fastest digit, a digit moves when all inner digits wrap.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_wrap[k] = ({1'b0, r_coord[k]} + SIZE_BITS'(1)) >= i_cfg.size[k];
        end
        w_inc[NUM_AXES-1] = 1'b1;
        for (int k = NUM_AXES - 2; k >= 0; k--) begin
            w_inc[k] = w_inc[k+1] & w_wrap[k+1];
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            if (!w_inc[k]) begin
                n_coord[k] = r_coord[k];
            end else if (w_wrap[k]) begin
                n_coord[k] = '0;
            end else begin
                n_coord[k] = r_coord[k] + COORD_BITS'(1);
            end
        end
    end

    assign o_q_push       = i_push & ~i_q_full;
    assign o_q_item.coord = r_coord;
    assign o_q_item.data  = i_data;
    assign o_q_item.last  = &w_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_coord <= '0;
        end else if (o_q_push) begin
            r_coord <= n_coord;
        end
    end

endmodule

// File: rtl/tap_queue.sv
// Short queue that decouples the front end from the index pipeline.
module tap_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tap_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_ready,
    output tap_pkg::t_item  o_item
);
    import tap_pkg::*;

    t_item                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic                  w_pop;

    assign o_full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + Q_CNT_BITS'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - Q_CNT_BITS'(1);
            end
        end
    end

endmodule

// File: rtl/tap_back.sv
// Back end: Horner-form destination index pipeline, error check and output register.
module tap_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tap_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  tap_pkg::t_item                  i_item,
    output logic                            o_valid,
    input  logic                            i_pop,
    output logic [tap_pkg::INDEX_BITS-1:0]  o_dest_index,
    output logic [tap_pkg::DATA_BITS-1:0]   o_data,
    output logic                            o_last,
    output logic [tap_pkg::ERR_BITS-1:0]    o_err
);
    import tap_pkg::*;

    localparam int P1_BITS = 2 * SIZE_BITS;
    localparam int P2_BITS = P1_BITS + SIZE_BITS;
    localparam int PC_BITS = INDEX_BITS + 1;
    localparam int P3_BITS = PC_BITS + SIZE_BITS;
    localparam int M1_BITS = COORD_BITS + SIZE_BITS;
    localparam int M2_BITS = INDEX_BITS + SIZE_BITS;
    localparam logic [PC_BITS-1:0] COUNT_LIMIT = PC_BITS'(1) << INDEX_BITS;

    // Stage valid bits and payload.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    t_item r_it1, r_it2, r_it3;

    logic [INDEX_BITS-1:0] r_acc1, r_acc2, r_acc3;
    logic [P1_BITS-1:0]    r_p1;
    logic [PC_BITS-1:0]    r_p2;
    logic                  r_over;

    logic [INDEX_BITS-1:0] r_idx;
    logic [DATA_BITS-1:0]  r_data;
    logic                  r_last;
    logic [ERR_BITS-1:0]   r_err;

    logic [COORD_BITS-1:0] w_c0, w_c1, w_c2, w_c3;
    logic [M1_BITS-1:0]    w_m1;
    logic [INDEX_BITS-1:0] w_s2, w_s3;
    logic [M2_BITS-1:0]    w_m2, w_m3;
    logic [P1_BITS-1:0]    w_p1;
    logic [P2_BITS-1:0]    w_p2;
    logic [P3_BITS-1:0]    w_p3;
    logic                  w_perm_ok;

    assign w_rdy4  = ~r_v4 | i_pop;
    assign w_rdy3  = ~r_v3 | w_rdy4;
    assign w_rdy2  = ~r_v2 | w_rdy3;
    assign w_rdy1  = ~r_v1 | w_rdy2;
    assign o_ready = w_rdy1;

    // Coordinates picked in destination-axis order, each at the stage that consumes it.
    assign w_c0 = i_item.coord[i_cfg.order[0]];
    assign w_c1 = r_it1.coord[i_cfg.order[1]];
    assign w_c2 = r_it2.coord[i_cfg.order[2]];
    assign w_c3 = r_it3.coord[i_cfg.order[3]];

    // The index is only kept modulo 2^INDEX_BITS, so each stage truncates.
    assign w_m1 = M1_BITS'(w_c0) * M1_BITS'(i_cfg.size[i_cfg.order[1]]);
    assign w_s2 = r_acc1 + INDEX_BITS'(w_c1);
    assign w_m2 = M2_BITS'(w_s2) * M2_BITS'(i_cfg.size[i_cfg.order[2]]);
    assign w_s3 = r_acc2 + INDEX_BITS'(w_c2);
    assign w_m3 = M2_BITS'(w_s3) * M2_BITS'(i_cfg.size[i_cfg.order[3]]);

    // Element count, saturated once it is known to be beyond the index range.
    assign w_p1 = P1_BITS'(i_cfg.size[0]) * P1_BITS'(i_cfg.size[1]);
    assign w_p2 = P2_BITS'(r_p1) * P2_BITS'(i_cfg.size[2]);
    assign w_p3 = P3_BITS'(r_p2) * P3_BITS'(i_cfg.size[3]);

    assign w_perm_ok = perm_ok(i_cfg.order);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_it1  <= i_item;
            r_acc1 <= w_m1[INDEX_BITS-1:0];
            r_p1   <= w_p1;
        end
        if (w_rdy2) begin
            r_it2  <= r_it1;
            r_acc2 <= w_m2[INDEX_BITS-1:0];
            r_p2   <= (w_p2 > P2_BITS'(COUNT_LIMIT)) ? COUNT_LIMIT + PC_BITS'(1)
                                                    : w_p2[PC_BITS-1:0];
        end
        if (w_rdy3) begin
            r_it3  <= r_it2;
            r_acc3 <= w_m3[INDEX_BITS-1:0];
            r_over <= (w_p3 > P3_BITS'(COUNT_LIMIT));
        end
        if (w_rdy4) begin
            r_data <= r_it3.data;
            r_last <= r_it3.last;
            if (!w_perm_ok) begin
                r_err <= ERR_ORDER;
                r_idx <= '0;
            end else if (r_over) begin
                r_err <= ERR_COUNT;
                r_idx <= '0;
            end else begin
                r_err <= ERR_NONE;
                r_idx <= r_acc3 + INDEX_BITS'(w_c3);
            end
        end
    end

    assign o_valid      = r_v4;
    assign o_dest_index = r_idx;
    assign o_data       = r_data;
    assign o_last       = r_last;
    assign o_err        = r_err;

`ifndef SYNTH
    a_err_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_err != ERR_NONE) |-> (r_idx == '0))
        else $error("error result carries a nonzero index");

    a_err_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_err == ERR_NONE || r_err == ERR_ORDER || r_err == ERR_COUNT))
        else $error("illegal error code on result");

    a_stall_holds_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_pop && r_v3) |=> r_v3)
        else $error("stage 3 item dropped while output stalled");

    a_no_take_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !i_pop) |-> !o_ready)
        else $error("pipeline takes an item while every stage is full and stalled");
`endif

endmodule

// File: rtl/tensor_axis_permute_addr.sv
// Top level of the 4-D tensor axis permutation scatter address generator.
//
// Usage: elements of a 4-D tensor enter in source row-major order (axis 3
// innermost) through a queue-style port: an item is taken at a clock edge with
// push high and full low. Each item leaves through the result port, oldest
// first, while empty is low, and is removed at an edge with pop high.
// A result carries the element unchanged, its linear index in the permuted
// tensor, a flag on the final element of the tensor, and an error code.
// Each accepted item passes through the queue, the three multiply stages of
// the Horner-form index computation and the output register; the block
// sustains one item per cycle as long as pop is high whenever empty is low.
// When pop stays low the pipeline fills and then a four-entry queue in front
// of it fills, after which full rises; no item is lost or repeated.
// Reset empties the queue and pipeline, sets all axis sizes to one, the axis
// order to identity, and the coordinate counter to zero. The user must write
// configuration only while the block holds no items, which the block does not
// enforce; any write to a valid register also restarts the coordinate counter.
module tensor_axis_permute_addr (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [tap_pkg::DATA_BITS-1:0]       i_element_bits,
    output logic                                empty,
    input  logic                                pop,
    output logic [tap_pkg::INDEX_BITS-1:0]      o_dest_index,
    output logic [tap_pkg::DATA_BITS-1:0]       o_element_out,
    output logic                                o_last_element,
    output logic [tap_pkg::ERR_BITS-1:0]        o_error_code,
    input  logic                                i_cfg_we,
    input  logic [tap_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tap_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import tap_pkg::*;

    // Raw configuration registers, as written.
    logic [NUM_AXES-1:0][SIZE_BITS-1:0]  r_size;
    logic [NUM_AXES-1:0][ORDER_BITS-1:0] r_order;

    t_cfg  w_cfg;
    logic  w_restart;
    logic  w_q_push;
    logic  w_q_full;
    logic  w_q_valid;
    logic  w_q_ready;
    logic  w_back_valid;
    t_item w_q_in;
    t_item w_q_out;

    // Writes beyond the register list are dropped and do not restart the counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_size[k]  <= SIZE_BITS'(1);
                r_order[k] <= ORDER_BITS'(k);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIZE_0:  r_size[0]  <= i_cfg_data;
                REG_SIZE_1:  r_size[1]  <= i_cfg_data;
                REG_SIZE_2:  r_size[2]  <= i_cfg_data;
                REG_SIZE_3:  r_size[3]  <= i_cfg_data;
                REG_ORDER_0: r_order[0] <= i_cfg_data[ORDER_BITS-1:0];
                REG_ORDER_1: r_order[1] <= i_cfg_data[ORDER_BITS-1:0];
                REG_ORDER_2: r_order[2] <= i_cfg_data[ORDER_BITS-1:0];
                REG_ORDER_3: r_order[3] <= i_cfg_data[ORDER_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_restart = i_cfg_we & (i_cfg_idx <= REG_ORDER_3);

    // The datapath sees clamped sizes: zero counts as one, large values saturate.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_cfg.size[k] = eff_size(r_size[k]);
        end
        w_cfg.order = r_order;
    end

    assign full = w_q_full;

    tap_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_data    (i_element_bits),
        .i_cfg     (w_cfg),
        .i_restart (w_restart),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_item  (w_q_in)
    );

    tap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_out)
    );

    tap_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (w_q_valid),
        .o_ready      (w_q_ready),
        .i_item       (w_q_out),
        .o_valid      (w_back_valid),
        .i_pop        (pop),
        .o_dest_index (o_dest_index),
        .o_data       (o_element_out),
        .o_last       (o_last_element),
        .o_err        (o_error_code)
    );

    assign empty = ~w_back_valid;

endmodule
